[design/rfd_pkg.sv]
// Shared types and constants for the rectangle fill display sequencer.
`default_nettype none

package rfd_pkg;

    // Display command bytes
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
    localparam logic [7:0] PAD_BYTE         = 8'h00;

    // Header byte positions; PIXEL_PHASE marks the colour stream
    localparam logic [3:0] STEP_COL_CMD   = 4'd0;
    localparam logic [3:0] STEP_COL_START = 4'd2;
    localparam logic [3:0] STEP_COL_END   = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD   = 4'd5;
    localparam logic [3:0] STEP_ROW_START = 4'd7;
    localparam logic [3:0] STEP_ROW_END   = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD   = 4'd10;
    localparam logic [3:0] PIXEL_PHASE    = 4'd11;

    // Item function codes
    localparam logic FUNC_FILL = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;
    localparam logic [1:0] STATUS_DROPPED  = 2'd3;

    // Classified job kinds
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_START     = 2'd1;
    localparam logic [1:0] KIND_OFFSCREEN = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
    localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

    localparam logic [7:0] SCREEN_WIDTH_RESET  = 8'd128;
    localparam logic [7:0] SCREEN_HEIGHT_RESET = 8'd160;

    typedef struct packed {
        logic        func;
        logic [7:0]  rect_x;
        logic [7:0]  rect_y;
        logic [7:0]  rect_w;
        logic [7:0]  rect_h;
        logic [15:0] fill_color;
    } rfd_in_t;

    typedef struct packed {
        logic       byte_valid;
        logic       is_data;
        logic [7:0] out_byte;
        logic       last_byte;
        logic [1:0] status;
    } rfd_out_t;

    typedef struct packed {
        logic [7:0] screen_width;
        logic [7:0] screen_height;
        logic [7:0] column_offset;
        logic [7:0] row_offset;
    } rfd_cfg_t;

    // Item after classification, as held in the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  col_start;
        logic [7:0]  col_end;
        logic [7:0]  row_start;
        logic [7:0]  row_end;
        logic [15:0] held_color;
        logic [15:0] pixel_count;
    } rfd_job_t;

endpackage : rfd_pkg

`default_nettype wire

[design/rect_fill_display_sequencer_unit.sv]
// Top level of the rectangle fill display sequencer.
// An accepted item is written into the job queue; the back end registers its result for output.
// Throughput: one item per cycle while the queue is not full; the queue (QUEUE_DEPTH entries)
// and the result register let the input side keep accepting while a result waits to be taken.
// Reset: rst_n (asynchronous, active low) empties the queue, clears the sequencer
// and sets the registers to 128, 160, 0 and 0.
`default_nettype none

module rect_fill_display_sequencer_unit
    import rfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Item channel
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire rfd_in_t     item,
    // Result channel
    output logic             result_valid,
    input  wire logic        result_ready,
    output rfd_out_t         result,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    rfd_cfg_t cfg;
    rfd_job_t front_job;
    rfd_job_t head_job;
    logic     queue_full;
    logic     queue_not_empty;
    logic     job_take;
    logic     item_xfer;

    assign item_ready = !queue_full;
    assign item_xfer  = item_valid && item_ready;

    // Configuration registers
    rfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Classify and clip
    rfd_front u_front (
        .item (item),
        .cfg  (cfg),
        .job  (front_job)
    );

    // Job queue
    rfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_xfer),
        .push_job  (front_job),
        .full      (queue_full),
        .pop       (job_take),
        .not_empty (queue_not_empty),
        .head      (head_job)
    );

    // Byte sequencer
    rfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (queue_not_empty),
        .job          (head_job),
        .job_take     (job_take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule : rect_fill_display_sequencer_unit

`default_nettype wire

[design/rfd_regs.sv]
// APB configuration registers: screen size and address offsets.
`default_nettype none

module rfd_regs
    import rfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output rfd_cfg_t         cfg
);

    rfd_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RESET;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RESET;
            cfg_reg.column_offset <= 8'd0;
            cfg_reg.row_offset    <= 8'd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[7:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[7:0];
                REG_COLUMN_OFFSET: cfg_reg.column_offset <= pwdata[7:0];
                REG_ROW_OFFSET:    cfg_reg.row_offset    <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = {24'd0, cfg_reg.screen_width};
            REG_SCREEN_HEIGHT: prdata = {24'd0, cfg_reg.screen_height};
            REG_COLUMN_OFFSET: prdata = {24'd0, cfg_reg.column_offset};
            REG_ROW_OFFSET:    prdata = {24'd0, cfg_reg.row_offset};
            default:           prdata = 32'd0;
        endcase
    end

endmodule : rfd_regs

`default_nettype wire

[design/rfd_front.sv]
// Front end: classifies items, clips rectangles and forms addresses and pixel count.
`default_nettype none

module rfd_front
    import rfd_pkg::*;
(
    input  wire rfd_in_t  item,
    input  wire rfd_cfg_t cfg,
    output rfd_job_t      job
);

    logic       off_screen;
    logic [8:0] x_reach;
    logic [8:0] y_reach;
    logic [7:0] clip_w;
    logic [7:0] clip_h;

    // Start outside the visible area
    assign off_screen = (item.rect_x >= cfg.screen_width) ||
                        (item.rect_y >= cfg.screen_height);

    // Clip size so the far edge stays on screen
    assign x_reach = {1'b0, item.rect_x} + {1'b0, item.rect_w};
    assign y_reach = {1'b0, item.rect_y} + {1'b0, item.rect_h};
    assign clip_w  = (x_reach >= ({1'b0, cfg.screen_width} + 9'd1)) ?
                     (cfg.screen_width - item.rect_x) : item.rect_w;
    assign clip_h  = (y_reach >= ({1'b0, cfg.screen_height} + 9'd1)) ?
                     (cfg.screen_height - item.rect_y) : item.rect_h;

    // Window addresses wrap at 8 bits; zero size gives start minus one
    always_comb
    begin
        if (item.func == FUNC_TICK)
            job.kind = KIND_TICK;
        else if (off_screen)
            job.kind = KIND_OFFSCREEN;
        else
            job.kind = KIND_START;
        job.col_start   = item.rect_x + cfg.column_offset;
        job.col_end     = item.rect_x + clip_w + cfg.column_offset - 8'd1;
        job.row_start   = item.rect_y + cfg.row_offset;
        job.row_end     = item.rect_y + clip_h + cfg.row_offset - 8'd1;
        job.held_color  = item.fill_color;
        job.pixel_count = 16'(clip_w) * 16'(clip_h);
    end

endmodule : rfd_front

`default_nettype wire

[design/rfd_queue.sv]
// Short FIFO of classified jobs between front and back ends.
`default_nettype none

module rfd_queue
    import rfd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire rfd_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          not_empty,
    output rfd_job_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rfd_job_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill level did not grow on push");
`endif

endmodule : rfd_queue

`default_nettype wire

[design/rfd_back.sv]
// Back end: fill sequencer state and registered result output.
`default_nettype none

module rfd_back
    import rfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     job_valid,
    input  wire rfd_job_t job,
    output logic          job_take,
    output logic          result_valid,
    input  wire logic     result_ready,
    output rfd_out_t      result
);

    logic        busy_reg,      busy_next;
    logic [3:0]  step_reg,      step_next;
    logic        low_next_reg,  low_next_next;
    logic [15:0] pixels_reg,    pixels_next;
    logic [7:0]  col_start_reg;
    logic [7:0]  col_end_reg;
    logic [7:0]  row_start_reg;
    logic [7:0]  row_end_reg;
    logic [15:0] color_reg;
    logic        result_valid_reg;
    rfd_out_t    result_reg,    result_next;
    logic        load_job;
    logic [15:0] pixels_dec;

    // Take a job whenever the result register is free or draining
    assign job_take     = job_valid && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pixels_dec   = pixels_reg - 16'd1;

    // Sequencer step
    always_comb
    begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        low_next_next = low_next_reg;
        pixels_next   = pixels_reg;
        load_job      = 1'b0;
        result_next   = '0;
        case (job.kind)
            KIND_OFFSCREEN:
            begin
                result_next.status = STATUS_REJECTED;
            end
            KIND_START:
            begin
                if (busy_reg)
                    result_next.status = STATUS_DROPPED;
                else
                begin
                    result_next.status = STATUS_ACCEPTED;
                    load_job      = 1'b1;
                    busy_next     = 1'b1;
                    step_next     = STEP_COL_CMD;
                    low_next_next = 1'b0;
                    pixels_next   = job.pixel_count;
                end
            end
            KIND_TICK:
            begin
                if (busy_reg && (step_reg != PIXEL_PHASE))
                begin
                    // Window and write commands
                    result_next.byte_valid = 1'b1;
                    result_next.is_data    = 1'b1;
                    case (step_reg)
                        STEP_COL_CMD:
                        begin
                            result_next.out_byte = CMD_COLUMN_SET;
                            result_next.is_data  = 1'b0;
                        end
                        STEP_COL_START: result_next.out_byte = col_start_reg;
                        STEP_COL_END:   result_next.out_byte = col_end_reg;
                        STEP_ROW_CMD:
                        begin
                            result_next.out_byte = CMD_ROW_SET;
                            result_next.is_data  = 1'b0;
                        end
                        STEP_ROW_START: result_next.out_byte = row_start_reg;
                        STEP_ROW_END:   result_next.out_byte = row_end_reg;
                        STEP_MEM_CMD:
                        begin
                            result_next.out_byte = CMD_MEMORY_WRITE;
                            result_next.is_data  = 1'b0;
                        end
                        default:        result_next.out_byte = PAD_BYTE;
                    endcase
                    if ((step_reg == STEP_MEM_CMD) && (pixels_reg == 16'd0))
                    begin
                        result_next.last_byte = 1'b1;
                        busy_next = 1'b0;
                        step_next = STEP_COL_CMD;
                    end
                    else
                        step_next = step_reg + 4'd1;
                end
                else if (busy_reg)
                begin
                    // Colour stream, high byte first
                    result_next.byte_valid = 1'b1;
                    result_next.is_data    = 1'b1;
                    if (!low_next_reg)
                    begin
                        result_next.out_byte = color_reg[15:8];
                        low_next_next = 1'b1;
                    end
                    else
                    begin
                        result_next.out_byte = color_reg[7:0];
                        low_next_next = 1'b0;
                        pixels_next   = pixels_dec;
                        if (pixels_dec == 16'd0)
                        begin
                            result_next.last_byte = 1'b1;
                            busy_next = 1'b0;
                            step_next = STEP_COL_CMD;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            step_reg         <= STEP_COL_CMD;
            low_next_reg     <= 1'b0;
            pixels_reg       <= 16'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_take)
            begin
                busy_reg     <= busy_next;
                step_reg     <= step_next;
                low_next_reg <= low_next_next;
                pixels_reg   <= pixels_next;
            end
            if (job_take)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // Window addresses, colour and result payload
    always_ff @(posedge clk)
    begin
        if (job_take && load_job)
        begin
            col_start_reg <= job.col_start;
            col_end_reg   <= job.col_end;
            row_start_reg <= job.row_start;
            row_end_reg   <= job.row_end;
            color_reg     <= job.held_color;
        end
        if (job_take)
            result_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= PIXEL_PHASE))
        else $error("header step beyond pixel phase");

    a_low_in_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        low_next_reg |-> (busy_reg && (step_reg == PIXEL_PHASE)))
        else $error("low colour half pending outside pixel phase");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (job_take && result_next.last_byte) |=> !busy_reg)
        else $error("sequencer still busy after last byte");
`endif

endmodule : rfd_back

`default_nettype wire

[test/fill_stream_checker.sv]
// Checker for the rectangle fill sequencer: mirrors the byte stream and compares results.
`timescale 1ns / 1ps

module fill_stream_checker
    import rfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire logic        item_ready,
    input  wire rfd_in_t     item,
    input  wire logic        result_valid,
    input  wire logic        result_ready,
    input  wire rfd_out_t    result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               failures,
    output int               pending
);

    // Mirror of the sequencer state and its registers
    rfd_cfg_t    cfg;
    logic        busy;
    logic [3:0]  step;
    logic [7:0]  col_start;
    logic [7:0]  col_end;
    logic [7:0]  row_start;
    logic [7:0]  row_end;
    logic [15:0] held_color;
    logic [15:0] pixels_left;
    logic        low_half_next;

    rfd_out_t    expected_bytes[$];

    task automatic report_failure(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        failures++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_failure($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Works out the display byte (or request status) caused by one item
    task automatic predict_display_byte(input rfd_in_t it, output rfd_out_t r);
        int unsigned x, y, w, h;
        r = '0;
        if (it.func == FUNC_FILL) begin
            x = it.rect_x;
            y = it.rect_y;
            w = it.rect_w;
            h = it.rect_h;
            if (x >= cfg.screen_width || y >= cfg.screen_height)
                r.status = STATUS_REJECTED;
            else if (busy)
                r.status = STATUS_DROPPED;
            else
            begin
                // clip to the visible area
                if (x + w >= int'(cfg.screen_width) + 1)
                    w = int'(cfg.screen_width) - x;
                if (y + h >= int'(cfg.screen_height) + 1)
                    h = int'(cfg.screen_height) - y;
                col_start     = 8'(x + cfg.column_offset);
                col_end       = 8'(x + w + 255 + cfg.column_offset);
                row_start     = 8'(y + cfg.row_offset);
                row_end       = 8'(y + h + 255 + cfg.row_offset);
                held_color    = it.fill_color;
                pixels_left   = 16'(w * h);
                low_half_next = 1'b0;
                step          = STEP_COL_CMD;
                busy          = 1'b1;
                r.status      = STATUS_ACCEPTED;
            end
        end
        else if (busy)
        begin
            r.byte_valid = 1'b1;
            r.is_data    = 1'b1;
            if (step < PIXEL_PHASE)
            begin
                // address window header
                r.out_byte = PAD_BYTE;
                case (step)
                    STEP_COL_CMD:   begin r.out_byte = CMD_COLUMN_SET; r.is_data = 1'b0; end
                    STEP_COL_START: r.out_byte = col_start;
                    STEP_COL_END:   r.out_byte = col_end;
                    STEP_ROW_CMD:   begin r.out_byte = CMD_ROW_SET; r.is_data = 1'b0; end
                    STEP_ROW_START: r.out_byte = row_start;
                    STEP_ROW_END:   r.out_byte = row_end;
                    STEP_MEM_CMD:   begin r.out_byte = CMD_MEMORY_WRITE; r.is_data = 1'b0; end
                    default:        r.out_byte = PAD_BYTE;
                endcase
                if (step == STEP_MEM_CMD && pixels_left == 16'd0)
                begin
                    r.last_byte = 1'b1;
                    busy        = 1'b0;
                    step        = STEP_COL_CMD;
                end
                else
                    step = step + 4'd1;
            end
            else if (!low_half_next)
            begin
                low_half_next = 1'b1;
                r.out_byte    = held_color[15:8];
            end
            else
            begin
                low_half_next = 1'b0;
                pixels_left   = pixels_left - 16'd1;
                r.out_byte    = held_color[7:0];
                if (pixels_left == 16'd0)
                begin
                    r.last_byte = 1'b1;
                    busy        = 1'b0;
                    step        = STEP_COL_CMD;
                end
            end
        end
    endtask

    initial
    begin
        failures = 0;
        pending  = 0;
    end

    // Results are checked before new items are predicted within one edge
    always @(posedge clk or negedge rst_n)
    begin
        rfd_out_t want;
        rfd_out_t next_byte;
        if (!rst_n)
        begin
            cfg           = '{screen_width: SCREEN_WIDTH_RESET,
                              screen_height: SCREEN_HEIGHT_RESET,
                              column_offset: 8'd0, row_offset: 8'd0};
            busy          = 1'b0;
            step          = STEP_COL_CMD;
            col_start     = 8'd0;
            col_end       = 8'd0;
            row_start     = 8'd0;
            row_end       = 8'd0;
            held_color    = 16'd0;
            pixels_left   = 16'd0;
            low_half_next = 1'b0;
            expected_bytes.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_failure($sformatf("result %h with nothing expected", result));
                else
                begin
                    want = expected_bytes.pop_front();
                    check_field("byte_valid", 8'(result.byte_valid), 8'(want.byte_valid));
                    check_field("is_data", 8'(result.is_data), 8'(want.is_data));
                    check_field("out_byte", result.out_byte, want.out_byte);
                    check_field("last_byte", 8'(result.last_byte), 8'(want.last_byte));
                    check_field("status", 8'(result.status), 8'(want.status));
                end
            end
            if (item_valid && item_ready)
            begin
                predict_display_byte(item, next_byte);
                expected_bytes.push_back(next_byte);
            end
            // register write transfer
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SCREEN_WIDTH:  cfg.screen_width  = pwdata[7:0];
                    REG_SCREEN_HEIGHT: cfg.screen_height = pwdata[7:0];
                    REG_COLUMN_OFFSET: cfg.column_offset = pwdata[7:0];
                    REG_ROW_OFFSET:    cfg.row_offset    = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        pending = expected_bytes.size();
    end

endmodule

[test/testbench.sv]
// Top of the rectangle fill sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import rfd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    rfd_in_t     item;
    logic        result_valid;
    logic        result_ready;
    rfd_out_t    result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          failures;
    int          pending;
    int          cycle_count;

    // Shadow of the screen size registers and of the sequence in flight, for shaping stimulus
    logic [7:0]  scr_w;
    logic [7:0]  scr_h;
    int          bytes_owed;
    bit          fast_items;

    rect_fill_display_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    fill_stream_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .failures     (failures),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rect_fill_display_sequencer_unit test failed");
            $finish;
        end
    end

    // Number of ticks an accepted request needs, zero if it would not be taken
    function automatic int fill_length(input rfd_in_t it);
        int cw, ch;
        if (it.rect_x >= scr_w || it.rect_y >= scr_h)
            return 0;
        cw = (int'(it.rect_x) + int'(it.rect_w) > int'(scr_w)) ? int'(scr_w) - int'(it.rect_x)
                                                               : int'(it.rect_w);
        ch = (int'(it.rect_y) + int'(it.rect_h) > int'(scr_h)) ? int'(scr_h) - int'(it.rect_y)
                                                               : int'(it.rect_h);
        return 11 + 2 * cw * ch;
    endfunction

    function automatic rfd_in_t random_fields();
        rfd_in_t it;
        it.func       = FUNC_TICK;
        it.rect_x     = 8'($urandom_range(0, 255));
        it.rect_y     = 8'($urandom_range(0, 255));
        it.rect_w     = 8'($urandom_range(0, 255));
        it.rect_h     = 8'($urandom_range(0, 255));
        it.fill_color = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    // Request with random content; forced off-screen when asked
    function automatic rfd_in_t random_request(input bit offscreen);
        rfd_in_t it;
        it      = random_fields();
        it.func = FUNC_FILL;
        if (offscreen)
        begin
            if ($urandom_range(0, 1) == 1)
                it.rect_x = 8'($urandom_range(int'(scr_w), 255));
            else
                it.rect_y = 8'($urandom_range(int'(scr_h), 255));
        end
        return it;
    endfunction

    // Start and size along one axis: mostly small, some clipped at the edge
    task automatic pick_span(input logic [7:0] limit, output logic [7:0] start,
                             output logic [7:0] size);
        int mode;
        mode = $urandom_range(0, 19);
        if (mode < 4)
        begin
            start = 8'(int'(limit) - 1 - $urandom_range(0, limit > 4 ? 3 : int'(limit) - 1));
            size  = 8'($urandom_range(0, 255));
        end
        else
        begin
            start = 8'($urandom_range(0, int'(limit) - 1));
            size  = 8'($urandom_range(0, mode == 4 ? 12 : 4));
        end
    endtask

    task automatic send_item(input rfd_in_t it);
        int gap;
        if ($urandom_range(0, 59) == 0)
            fast_items = !fast_items;
        gap = fast_items ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
        // keep track of the sequence being streamed
        if (it.func == FUNC_TICK)
        begin
            if (bytes_owed > 0)
                bytes_owed--;
        end
        else if (bytes_owed == 0)
            bytes_owed = fill_length(it);
    endtask

    task automatic wait_drained();
        item_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] w, input logic [7:0] h,
                                input logic [7:0] col_off, input logic [7:0] row_off);
        wait_drained();
        write_register(REG_SCREEN_WIDTH, w);
        write_register(REG_SCREEN_HEIGHT, h);
        write_register(REG_COLUMN_OFFSET, col_off);
        write_register(REG_ROW_OFFSET, row_off);
        scr_w = w;
        scr_h = h;
    endtask

    // Mostly complete fill sequences, with stray requests and idle ticks
    task automatic random_phase(input int count);
        rfd_in_t it;
        for (int n = 0; n < count || bytes_owed > 0; n++)
        begin
            if ($urandom_range(0, 149) == 0)
                wait_drained();
            if (bytes_owed > 0)
                it = ($urandom_range(0, 6) == 0) ? random_request(1'b0) : random_fields();
            else if (scr_w == 8'd0 || scr_h == 8'd0 || $urandom_range(0, 9) < 3)
                it = ($urandom_range(0, 1) == 1) ? random_fields() : random_request(1'b1);
            else
            begin
                it      = random_request(1'b0);
                pick_span(scr_w, it.rect_x, it.rect_w);
                pick_span(scr_h, it.rect_y, it.rect_h);
            end
            send_item(it);
        end
    endtask

    // Result side: random stalls with stretches of none
    initial
    begin : result_side
        int  stall;
        bit  fast_results;
        fast_results = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                fast_results = !fast_results;
            stall = fast_results ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready = 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        rfd_in_t it;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        scr_w      = SCREEN_WIDTH_RESET;
        scr_h      = SCREEN_HEIGHT_RESET;
        bytes_owed = 0;
        fast_items = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle ticks with all-zero and all-one payloads
        it      = '0;
        it.func = FUNC_TICK;
        send_item(it);
        it = '1;
        send_item(it);
        // starts just off the right and the bottom edge
        it        = '0;
        it.func   = FUNC_FILL;
        it.rect_x = SCREEN_WIDTH_RESET;
        it.rect_w = 8'hFF;
        send_item(it);
        it        = '0;
        it.func   = FUNC_FILL;
        it.rect_y = SCREEN_HEIGHT_RESET;
        it.rect_h = 8'hFF;
        send_item(it);
        // zero height: header only, with a request dropped while busy
        it            = '0;
        it.func       = FUNC_FILL;
        it.rect_w     = 8'd5;
        it.fill_color = 16'hFFFF;
        send_item(it);
        for (int n = 0; n < 12; n++)
        begin
            if (n == 5)
            begin
                it        = '0;
                it.func   = FUNC_FILL;
                it.rect_w = 8'd1;
                it.rect_h = 8'd1;
                send_item(it);
            end
            it      = '0;
            it.func = FUNC_TICK;
            send_item(it);
        end

        random_phase(230);
        apply_config(8'd255, 8'd255, 8'd255, 8'd255);
        random_phase(300);
        apply_config(8'd1, 8'd1, 8'd0, 8'd0);
        random_phase(200);
        // zero screen size rejects every fill request
        apply_config(8'd0, 8'd0, 8'd17, 8'd3);
        random_phase(40);
        repeat (3)
        begin
            apply_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            random_phase(250);
        end

        item_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (failures == 0)
            $display("rect_fill_display_sequencer_unit test passed");
        else
            $display("rect_fill_display_sequencer_unit test failed");
        $finish;
    end

endmodule

[rect_fill_display_sequencer_unit.f]
design/rfd_pkg.sv
design/rfd_regs.sv
design/rfd_front.sv
design/rfd_queue.sv
design/rfd_back.sv
design/rect_fill_display_sequencer_unit.sv
test/fill_stream_checker.sv
test/testbench.sv
